>>> hw/rtl/ultrasonic_range_to_pwm_defines.svh
// Assertion macros shared by the checker.
`ifndef ULTRASONIC_RANGE_TO_PWM_DEFINES_SVH
`define ULTRASONIC_RANGE_TO_PWM_DEFINES_SVH
// Assert that an implication holds on every clock edge outside reset.
`define URP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an implication holds in the next cycle.
`define URP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/urp_pkg.sv
package urp_pkg;
  localparam int unsigned PreLowTicks   = 32;
  localparam int unsigned EchoCountBits = 20;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 24;
  localparam int unsigned DistW         = 13;
  localparam int unsigned DutyW         = 8;
  localparam int unsigned PhaseW        = 3;
  localparam int unsigned FifoDepth     = 2;

  localparam logic [CfgIdxW-1:0] RegPwmTop   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTrigHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScale    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNear     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFar      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDutyNear = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDutyFar  = 3'd7;

  typedef struct packed {
    logic [7:0]  pwm_top;
    logic [11:0] trig_high;
    logic [19:0] timeout;
    logic [23:0] scale;
    logic [12:0] near_mm;
    logic [12:0] far_mm;
    logic [7:0]  duty_near;
    logic [7:0]  duty_far;
  } cfg_t;

  typedef struct packed {
    logic echo_level;
    logic start_request;
  } tick_t;
endpackage

>>> hw/rtl/urp_front.sv
module urp_front #(
  parameter int unsigned Depth = urp_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  urp_pkg::tick_t in_tick_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output urp_pkg::tick_t q_tick_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  urp_pkg::tick_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_tick_o   = mem_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_tick_i;
    end
  end
endmodule

>>> hw/rtl/urp_back.sv
module urp_back #(
  parameter int unsigned PreLowTicks   = urp_pkg::PreLowTicks,
  parameter int unsigned EchoCountBits = urp_pkg::EchoCountBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  urp_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  urp_pkg::tick_t q_tick_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           trigger_level_o,
  output logic           pwm_level_o,
  output logic           busy_res_o,
  output logic           result_done_o,
  output logic           timed_out_o,
  output logic [12:0]    distance_mm_o,
  output logic [7:0]     duty_value_o
);
  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhPrelow = 3'd1;
  localparam logic [2:0] PhTrig   = 3'd2;
  localparam logic [2:0] PhWait   = 3'd3;
  localparam logic [2:0] PhCount  = 3'd4;
  localparam logic [2:0] PhMul    = 3'd5;
  localparam logic [2:0] PhMap    = 3'd6;
  localparam logic [2:0] PhDiv    = 3'd7;
  localparam int unsigned EW = EchoCountBits;
  localparam int unsigned PW = EW + 1 + 24;
  localparam int unsigned CW = (EW > 20) ? EW : 20;

  logic [2:0]    ph_q, ph_d;
  logic [11:0]   pt_q, pt_d;
  logic [EW-1:0] et_q, et_d;
  logic [7:0]    pc_q, pc_d, dp_q, dp_d, da_q, da_d;
  logic [12:0]   ld_q, ld_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [21:0]   num_q, num_d;
  logic [12:0]   den_q, den_d;
  logic [8:0]    quo_q, quo_d;
  logic [4:0]    it_q, it_d;
  logic          neg_q, neg_d;
  logic [13:0]   rem_q, rem_d;
  logic          ov_q, ov_d;
  logic          ot_q, ot_d, op_q, op_d, ob_q, ob_d, od_q, od_d, oto_q, oto_d;

  logic          step;
  logic          tmo_hit;
  logic [PW-25:0] mm_full;
  logic [12:0]   mm_sat, xcl;
  logic signed [9:0]  ddiff;
  logic [8:0]    dmag;
  logic [21:0]   nmag;
  logic [13:0]   rtry;
  logic [8:0]    qfin;
  logic [9:0]    dres;

  // Phases past PhCount stall the tick queue while the result is formed.
  assign q_ready_o   = (!ov_q || out_ready_i) && (ph_q <= PhCount);
  assign step        = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign trigger_level_o = ot_q;
  assign pwm_level_o     = op_q;
  assign busy_res_o      = ob_q;
  assign result_done_o   = od_q;
  assign timed_out_o     = oto_q;
  assign distance_mm_o   = ld_q;
  assign duty_value_o    = dp_q;

  assign tmo_hit = (CW'(et_q) >= CW'(cfg_i.timeout)) || (et_q == '1);
  assign mm_full = prod_q[PW-1:24];
  assign mm_sat  = (mm_full > (PW-24)'(8191)) ? 13'd8191 : mm_full[12:0];
  assign xcl     = (ld_q < cfg_i.near_mm) ? cfg_i.near_mm :
                   (ld_q > cfg_i.far_mm) ? cfg_i.far_mm : ld_q;
  assign ddiff   = $signed({2'b0, cfg_i.duty_far}) - $signed({2'b0, cfg_i.duty_near});
  assign dmag    = ddiff[9] ? 9'(-ddiff) : ddiff[8:0];
  assign nmag    = 22'(xcl - cfg_i.near_mm) * 22'(dmag);
  assign rtry    = {rem_q[12:0], num_q[21]};
  // Negative quotient rounds toward minus infinity.
  assign qfin    = (neg_q && rem_q != '0) ? quo_q + 1'b1 : quo_q;
  assign dres    = neg_q ? 10'({2'b0, cfg_i.duty_near}) - 10'(qfin)
                         : 10'({2'b0, cfg_i.duty_near}) + 10'(qfin);

  always_comb begin
    ph_d = ph_q; pt_d = pt_q; et_d = et_q; pc_d = pc_q; dp_d = dp_q; da_d = da_q;
    ld_d = ld_q; prod_d = prod_q; num_d = num_q; den_d = den_q;
    quo_d = quo_q; it_d = it_q; neg_d = neg_q; rem_d = rem_q;
    ov_d = ov_q; ot_d = ot_q; op_d = op_q; ob_d = ob_q; od_d = od_q; oto_d = oto_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (ph_q)
      PhMul: begin
        ld_d = mm_sat;
        ph_d = PhMap;
      end
      PhMap: begin
        if (cfg_i.far_mm <= cfg_i.near_mm) begin
          dp_d = (ld_q <= cfg_i.near_mm) ? cfg_i.duty_near : cfg_i.duty_far;
          if (pc_q == '0) begin
            da_d = dp_d;
          end
          ov_d = 1'b1;
          ph_d = PhIdle;
        end else begin
          num_d = nmag;
          den_d = cfg_i.far_mm - cfg_i.near_mm;
          neg_d = ddiff[9];
          rem_d = '0;
          quo_d = '0;
          it_d  = '0;
          ph_d  = PhDiv;
        end
      end
      PhDiv: begin
        if (it_q == 5'd22) begin
          dp_d = dres[7:0];
          if (pc_q == '0) begin
            da_d = dp_d;
          end
          ov_d = 1'b1;
          ph_d = PhIdle;
        end else begin
          num_d = {num_q[20:0], 1'b0};
          it_d  = it_q + 1'b1;
          if (rtry >= {1'b0, den_q}) begin
            rem_d = rtry - {1'b0, den_q};
            quo_d = {quo_q[7:0], 1'b1};
          end else begin
            rem_d = rtry;
            quo_d = {quo_q[7:0], 1'b0};
          end
        end
      end
      default: begin
        if (step) begin
          od_d  = 1'b0;
          oto_d = 1'b0;
          unique case (ph_q)
            PhIdle: begin
              if (q_tick_i.start_request) begin
                ph_d = PhPrelow;
                pt_d = '0;
              end
            end
            PhPrelow: begin
              pt_d = pt_q + 1'b1;
              if (pt_d >= 12'(PreLowTicks)) begin
                ph_d = PhTrig;
                pt_d = '0;
              end
            end
            PhTrig: begin
              pt_d = pt_q + 1'b1;
              if (pt_d >= cfg_i.trig_high) begin
                ph_d = PhWait;
                pt_d = '0;
              end
            end
            PhWait: begin
              if (q_tick_i.echo_level) begin
                ph_d = PhCount;
                et_d = '0;
              end
            end
            default: begin
              if (tmo_hit || !q_tick_i.echo_level) begin
                oto_d  = tmo_hit;
                od_d   = 1'b1;
                prod_d = PW'(({1'b0, et_q} + 1'b1)) * PW'(cfg_i.scale);
                pt_d   = '0;
                ph_d   = PhMul;
              end else begin
                et_d = et_q + 1'b1;
              end
            end
          endcase
          op_d = (pc_q <= da_q);
          if (pc_q >= cfg_i.pwm_top) begin
            pc_d = '0;
            da_d = dp_q;
          end else begin
            pc_d = pc_q + 1'b1;
          end
          ot_d = (ph_d == PhTrig);
          ob_d = (ph_d != PhIdle) && (ph_d < PhMul);
          ov_d = (ph_d != PhMul);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; pt_q <= '0; et_q <= '0; pc_q <= '0; dp_q <= '0; da_q <= '0;
      ld_q <= '0; ov_q <= 1'b0; it_q <= '0;
      ot_q <= 1'b0; op_q <= 1'b0; ob_q <= 1'b0; od_q <= 1'b0; oto_q <= 1'b0;
    end else begin
      ph_q <= ph_d; pt_q <= pt_d; et_q <= et_d; pc_q <= pc_d; dp_q <= dp_d; da_q <= da_d;
      ld_q <= ld_d; ov_q <= ov_d; it_q <= it_d;
      ot_q <= ot_d; op_q <= op_d; ob_q <= ob_d; od_q <= od_d; oto_q <= oto_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; num_q <= num_d; den_q <= den_d; quo_q <= quo_d;
    neg_q <= neg_d; rem_q <= rem_d;
  end
endmodule

>>> hw/rtl/ultrasonic_range_to_pwm.sv
// Ultrasonic rangefinder with fast-PWM output.
// Input channel: one item per timer tick (echo_level_i, start_request_i),
// taken on in_valid_i && in_ready_o. Output channel: one item per input item
// (trigger, pwm, busy, done, timeout, distance, duty) on out_valid_o &&
// out_ready_i, in order.
// Config: cfg_we_i writes register cfg_idx_i with cfg_data_i at once.
// An item's result is registered and appears in the cycle after it leaves
// the tick queue; the item of the tick that ends a measurement appears once
// the distance and duty are formed in the PhMul and PhMap phases, and in the
// 22-step shift-subtract divider (PhDiv) when the distance goes through it.
// Throughput: one item per cycle while the output is taken, except in
// the PhMul to PhDiv phases after a measurement ends, when no tick is taken.
// A two-entry tick queue sits between the input and the measurement logic.
// Reset: idle, counters and duties zero, registers at their defaults.
// A stalled receiver holds the output item and stops the queue draining;
// the input keeps being accepted until the queue is full.
// Timed_out is also flagged if the echo count reaches its width limit.
// Distance saturates at 8191 mm.
module ultrasonic_range_to_pwm #(
  parameter int unsigned PreLowTicks   = urp_pkg::PreLowTicks,
  parameter int unsigned EchoCountBits = urp_pkg::EchoCountBits,
  parameter int unsigned FifoDepth     = urp_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        echo_level_i,
  input  logic        start_request_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        trigger_level_o,
  output logic        pwm_level_o,
  output logic        busy_res_o,
  output logic        result_done_o,
  output logic        timed_out_o,
  output logic [12:0] distance_mm_o,
  output logic [7:0]  duty_value_o
);
  urp_pkg::cfg_t  cfg_q;
  urp_pkg::tick_t in_tick, q_tick;
  logic           q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_top   <= 8'd196;
      cfg_q.trig_high <= 12'd176;
      cfg_q.timeout   <= 20'd559677;
      cfg_q.scale     <= 24'd179831;
      cfg_q.near_mm   <= 13'd10;
      cfg_q.far_mm    <= 13'd300;
      cfg_q.duty_near <= 8'd195;
      cfg_q.duty_far  <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        urp_pkg::RegPwmTop:   cfg_q.pwm_top   <= cfg_data_i[7:0];
        urp_pkg::RegTrigHigh: cfg_q.trig_high <= cfg_data_i[11:0];
        urp_pkg::RegTimeout:  cfg_q.timeout   <= cfg_data_i[19:0];
        urp_pkg::RegScale:    cfg_q.scale     <= cfg_data_i;
        urp_pkg::RegNear:     cfg_q.near_mm   <= cfg_data_i[12:0];
        urp_pkg::RegFar:      cfg_q.far_mm    <= cfg_data_i[12:0];
        urp_pkg::RegDutyNear: cfg_q.duty_near <= cfg_data_i[7:0];
        default:              cfg_q.duty_far  <= cfg_data_i[7:0];
      endcase
    end
  end

  assign in_tick.echo_level    = echo_level_i;
  assign in_tick.start_request = start_request_i;

  urp_front #(.Depth(FifoDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_tick_i(in_tick),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_tick_o(q_tick)
  );

  urp_back #(.PreLowTicks(PreLowTicks), .EchoCountBits(EchoCountBits)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_tick_i(q_tick), .out_valid_o, .out_ready_i, .trigger_level_o, .pwm_level_o,
    .busy_res_o, .result_done_o, .timed_out_o, .distance_mm_o, .duty_value_o
  );
endmodule

>>> hw/rtl/urp_checker.sv
`include "ultrasonic_range_to_pwm_defines.svh"
module urp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic trigger_level_o,
  input logic busy_res_o,
  input logic result_done_o,
  input logic timed_out_o
);
  `URP_ASSERT_IMP(a_tout_done, clk_i, rst_ni, out_valid_o && timed_out_o, result_done_o)
  `URP_ASSERT_IMP(a_trig_busy, clk_i, rst_ni, out_valid_o && trigger_level_o, busy_res_o)
  `URP_ASSERT_IMP(a_done_idle, clk_i, rst_ni, out_valid_o && result_done_o, !busy_res_o)
  `URP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `URP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i)
endmodule

bind ultrasonic_range_to_pwm urp_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .trigger_level_o, .busy_res_o, .result_done_o, .timed_out_o
);

>>> bench/tb.sv
module tb;
  typedef enum logic [2:0] {
    MS_IDLE   = 3'd0,
    MS_PRELOW = 3'd1,
    MS_TRIG   = 3'd2,
    MS_WAIT   = 3'd3,
    MS_COUNT  = 3'd4
  } meas_phase_e;

  typedef struct packed {
    logic        trigger;
    logic        pwm;
    logic        busy;
    logic        done;
    logic        tout;
    logic [12:0] dist_mm;
    logic [7:0]  duty;
  } tick_out_t;

  typedef struct packed {
    logic      echo;
    logic      start;
    logic      typed;
    tick_out_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        echo_level_i = 1'b0;
  logic        start_request_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        trigger_level_o, pwm_level_o, busy_res_o, result_done_o, timed_out_o;
  logic [12:0] distance_mm_o;
  logic [7:0]  duty_value_o;

  ultrasonic_range_to_pwm dut (.*);

  always #1 clk_i = ~clk_i;

  // predicted block state and registers
  logic [7:0]  top_r, dnear_r, dfar_r;
  logic [11:0] trig_r;
  logic [19:0] tmo_r;
  logic [23:0] scale_r;
  logic [12:0] near_r, far_r;
  meas_phase_e ph;
  logic [11:0] ph_ticks;
  logic [19:0] echo_cnt;
  logic [7:0]  pwm_cnt, duty_pend, duty_act;
  logic [12:0] last_dist;

  tick_out_t   pending_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  int unsigned stall = 0;

  task automatic report(input string what, input longint got, input longint want);
    if (mismatches < 40) $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic [7:0] duty_for(input logic [12:0] d);
    longint x, num, den, q;
    if (far_r <= near_r) return (d <= near_r) ? dnear_r : dfar_r;
    x = d;
    if (x < near_r) x = near_r;
    if (x > far_r) x = far_r;
    num = (x - near_r) * (longint'(dfar_r) - longint'(dnear_r));
    den = far_r - near_r;
    q = (num >= 0) ? num / den : -((-num + den - 1) / den);
    return 8'(longint'(dnear_r) + q);
  endfunction

  task automatic range_done();
    longint unsigned mm;
    mm = ((longint'(echo_cnt) + 1) * scale_r) >> 24;
    if (mm > 8191) mm = 8191;
    last_dist = 13'(mm);
    duty_pend = duty_for(last_dist);
    ph = MS_IDLE;
    ph_ticks = '0;
  endtask

  task automatic predict_tick(input logic echo, input logic start, output tick_out_t r);
    r = '0;
    case (ph)
      MS_IDLE: if (start) begin
        ph = MS_PRELOW;
        ph_ticks = '0;
      end
      MS_PRELOW: begin
        ph_ticks++;
        if (ph_ticks >= urp_pkg::PreLowTicks) begin
          ph = MS_TRIG;
          ph_ticks = '0;
        end
      end
      MS_TRIG: begin
        ph_ticks++;
        if (ph_ticks >= trig_r) begin
          ph = MS_WAIT;
          ph_ticks = '0;
        end
      end
      MS_WAIT: if (echo) begin
        ph = MS_COUNT;
        echo_cnt = '0;
      end
      MS_COUNT: begin
        if (echo_cnt >= tmo_r || echo_cnt == 20'hFFFFF) begin
          r.tout = 1'b1;
          r.done = 1'b1;
          range_done();
        end else if (!echo) begin
          r.done = 1'b1;
          range_done();
        end else begin
          echo_cnt++;
        end
      end
      default: begin
        ph = MS_IDLE;
        ph_ticks = '0;
      end
    endcase
    r.pwm = (pwm_cnt <= duty_act);
    if (pwm_cnt >= top_r) begin
      pwm_cnt = '0;
      duty_act = duty_pend;
    end else begin
      pwm_cnt++;
    end
    r.trigger = (ph == MS_TRIG);
    r.busy = (ph != MS_IDLE);
    r.dist_mm = last_dist;
    r.duty = duty_pend;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      urp_pkg::RegPwmTop:   top_r = val[7:0];
      urp_pkg::RegTrigHigh: trig_r = val[11:0];
      urp_pkg::RegTimeout:  tmo_r = val[19:0];
      urp_pkg::RegScale:    scale_r = val;
      urp_pkg::RegNear:     near_r = val[12:0];
      urp_pkg::RegFar:      far_r = val[12:0];
      urp_pkg::RegDutyNear: dnear_r = val[7:0];
      default:              dfar_r = val[7:0];
    endcase
  endtask

  task automatic settle();
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [7:0] top, input logic [11:0] trig,
                              input logic [19:0] tmo, input logic [23:0] scale,
                              input logic [12:0] nr, input logic [12:0] fr,
                              input logic [7:0] dn, input logic [7:0] df);
    in_valid_i <= 1'b0;
    settle();
    cfg_write(urp_pkg::RegPwmTop, 24'(top));
    cfg_write(urp_pkg::RegTrigHigh, 24'(trig));
    cfg_write(urp_pkg::RegTimeout, 24'(tmo));
    cfg_write(urp_pkg::RegScale, scale);
    cfg_write(urp_pkg::RegNear, 24'(nr));
    cfg_write(urp_pkg::RegFar, 24'(fr));
    cfg_write(urp_pkg::RegDutyNear, 24'(dn));
    cfg_write(urp_pkg::RegDutyFar, 24'(df));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(input logic echo, input logic start, output tick_out_t r);
    int unsigned gap, pick;
    in_valid_i <= 1'b1;
    echo_level_i <= echo;
    start_request_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    predict_tick(echo, start, r);
    pending_q.push_back(r);
    pick = $urandom_range(0, 99);
    gap = (pick < 70) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (cycles[12:11] == 2'd0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_items(input int unsigned count);
    tick_out_t r;
    logic echo, start;
    repeat (count) begin
      echo = $urandom_range(0, 1);
      start = $urandom_range(0, 1);
      if ($urandom_range(0, 19) != 0) begin
        case (ph)
          MS_IDLE:  start = ($urandom_range(0, 2) == 0);
          MS_WAIT:  echo = ($urandom_range(0, 3) == 0);
          MS_COUNT: echo = ($urandom_range(0, 15) != 0);
          default:  ;
        endcase
      end
      send_item(echo, start, r);
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 13'd0, 8'd0}},
    '{1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0, 8'd0}},
    '{1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 13'd0, 8'd0}},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0}
  };

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == 3000) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    if (cycles > 2_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
    end else if (stall != 0) begin
      stall <= stall - 1;
      out_ready_i <= 1'b0;
    end else if (cycles[12:11] != 2'd1 && pick < 12) begin
      stall <= (pick < 11) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tick_out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report("unexpected item", 1, 0);
      end else begin
        w = pending_q.pop_front();
        if (trigger_level_o !== w.trigger) report("trigger", trigger_level_o, w.trigger);
        if (pwm_level_o !== w.pwm) report("pwm", pwm_level_o, w.pwm);
        if (busy_res_o !== w.busy) report("busy", busy_res_o, w.busy);
        if (result_done_o !== w.done) report("done", result_done_o, w.done);
        if (timed_out_o !== w.tout) report("timeout", timed_out_o, w.tout);
        if (distance_mm_o !== w.dist_mm) report("distance", distance_mm_o, w.dist_mm);
        if (duty_value_o !== w.duty) report("duty", duty_value_o, w.duty);
      end
    end
  end

  initial begin
    tick_out_t r;
    top_r = 8'd196; trig_r = 12'd176; tmo_r = 20'd559677; scale_r = 24'd179831;
    near_r = 13'd10; far_r = 13'd300; dnear_r = 8'd195; dfar_r = 8'd10;
    ph = MS_IDLE; ph_ticks = '0; echo_cnt = '0; pwm_cnt = '0;
    duty_pend = '0; duty_act = '0; last_dist = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].echo, dir_rows[i].start, r);
      if (dir_rows[i].typed && r !== dir_rows[i].want) report("directed row", i, i);
    end
    random_items(250);
    load_setting(8'd3, 12'd0, 20'd40, 24'hFFFFFF, 13'd0, 13'd8191, 8'd0, 8'd255);
    random_items(180);
    load_setting(8'd1, 12'd4095, 20'd0, 24'd1, 13'd8191, 13'd0, 8'd255, 8'd0);
    random_items(160);
    load_setting(8'd255, 12'd5, 20'hFFFFF, 24'h400000, 13'd20, 13'd60, 8'd200, 8'd30);
    random_items(180);
    load_setting(8'd100, 12'd1, 20'd200, 24'd3000000, 13'd100, 13'd90, 8'd17, 8'd240);
    random_items(170);
    load_setting(8'd0, 12'd2, 20'd1, 24'd12345678, 13'd1, 13'd2, 8'd128, 8'd127);
    random_items(160);
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/urp_pkg.sv
hw/rtl/urp_front.sv
hw/rtl/urp_back.sv
hw/rtl/ultrasonic_range_to_pwm.sv
hw/rtl/urp_checker.sv
bench/tb.sv
